// ----- sv/fatlb_pkg.sv -----
// Package for the fully associative translation buffer.
// Holds transaction payload types, mode codes and the controller/datapath
// command and status structs. No dependencies.
package fatlb_pkg;

  localparam int unsigned PROC_W  = 8;
  localparam int unsigned PAGE_W  = 14;
  localparam int unsigned FRAME_W = 8;

  // Request mode codes.
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_INSERT = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [PROC_W-1:0]  proc_id;
    logic [PAGE_W-1:0]  page_number;
    logic [FRAME_W-1:0] frame_in;
  } fatlb_req_t;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame_out;
  } fatlb_rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;    // capture the incoming request
    logic scan_start;  // rewind the lookup scan to entry zero
    logic scan_run;    // advance the lookup scan by one entry
    logic do_write;    // write the held request into the buffer
    logic capture_res; // take the scan's compare result as the response
    logic clear_res;   // take an all-zero response
    logic load_out;    // move the response into the output register
  } fatlb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_mode;   // mode of the request at the input
    logic empty;     // no entry has been filled yet
    logic match;     // the entry just read matches the held request
    logic scan_end;  // the entry just read is the last filled one
  } fatlb_sts_t;

endpackage

// ----- sv/fifo_fully_associative_tlb_core.sv -----
// Top level of the fully associative translation buffer with FIFO replacement.
// Instantiates fatlb_ctrl and fatlb_datapath; types come from fatlb_pkg.
//
//   Channel   Direction  Handshake              Payload
//   request   in         in_valid_i/in_ready_o  in_req_i  (fatlb_req_t)
//   response  out        out_valid_o/out_ready_i out_rsp_o (fatlb_rsp_t)
//
// Sequence: an insert writes its entry and then loads its response. A lookup
// walks the filled entries one per cycle through the single read port of the
// entry memory and stops at the first hit or after the last filled entry; a
// lookup on an empty buffer answers a miss without any scan. The next request
// is accepted in the cycle after the response register is loaded. Reset: the
// fill count, victim pointer and handshake state clear at once; the memory
// needs no clearing pass. Stalls: a response waiting in the output register
// does not block the next request, which is held in its final step only until
// the output register frees up.
module fifo_fully_associative_tlb_core #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  fatlb_pkg::fatlb_req_t in_req_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output fatlb_pkg::fatlb_rsp_t out_rsp_o
);
  import fatlb_pkg::*;

  // Command and status buses between the controller and the datapath.
  fatlb_cmd_t cmd;
  fatlb_sts_t sts;

  // The controller owns the handshakes and the sequence of each request.
  fatlb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the entries, the replacement state and the
  // response registers.
  fatlb_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_req_i  (in_req_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_rsp_o (out_rsp_o)
  );

endmodule

// ----- sv/fatlb_ctrl.sv -----
// Controller state machine for the translation buffer.
// Depends on fatlb_pkg for the command and status structs.
module fatlb_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  fatlb_pkg::fatlb_sts_t sts_i,
  output fatlb_pkg::fatlb_cmd_t cmd_o
);
  import fatlb_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WRITE = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign in_acc      = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_o.load_req = 1'b1;
          if (sts_i.in_mode == MODE_INSERT) begin
            state_d = ST_WRITE;
          end else if (sts_i.empty) begin
            cmd_o.clear_res = 1'b1;
            state_d         = ST_DONE;
          end else begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end
        end
      end
      ST_WRITE: begin
        cmd_o.do_write  = 1'b1;
        cmd_o.clear_res = 1'b1;
        state_d         = ST_DONE;
      end
      ST_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.match || sts_i.scan_end) begin
          cmd_o.capture_res = 1'b1;
          state_d           = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- sv/fatlb_datapath.sv -----
// Datapath of the translation buffer: entry memory, fill count, victim
// pointer, scan counter, compare and response registers. Uses fatlb_pkg.
module fatlb_datapath #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fatlb_pkg::fatlb_req_t in_req_i,
  input  fatlb_pkg::fatlb_cmd_t cmd_i,
  output fatlb_pkg::fatlb_sts_t sts_o,
  output fatlb_pkg::fatlb_rsp_t out_rsp_o
);
  import fatlb_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = IDX_W + 1;

  typedef struct packed {
    logic [PROC_W-1:0]  proc_id;
    logic [PAGE_W-1:0]  page_number;
    logic [FRAME_W-1:0] frame;
  } entry_t;

  entry_t             mem_q [ENTRIES];
  entry_t             rd_q;
  fatlb_req_t         req_q;
  fatlb_rsp_t         res_q, out_q;

  logic [CNT_W-1:0]   count_q, count_d;
  logic [IDX_W-1:0]   victim_q, victim_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic               issue_q, issue_d;
  logic               rd_vld_q, rd_vld_d;
  logic               rd_last_q, rd_last_d;

  logic               full;
  logic [CNT_W-1:0]   count_m1;
  logic [IDX_W-1:0]   last_idx;
  logic [IDX_W-1:0]   wr_idx;
  logic               rd_en;
  logic               match;

  assign full     = (count_q == CNT_W'(ENTRIES));
  assign count_m1 = count_q - 1'b1;
  assign last_idx = count_m1[IDX_W-1:0];
  assign wr_idx   = full ? victim_q : count_q[IDX_W-1:0];
  assign rd_en    = cmd_i.scan_run && issue_q;
  assign match    = rd_vld_q && (rd_q.proc_id == req_q.proc_id)
                    && (rd_q.page_number == req_q.page_number);

  assign sts_o.in_mode  = in_req_i.mode;
  assign sts_o.empty    = (count_q == '0);
  assign sts_o.match    = match;
  assign sts_o.scan_end = rd_vld_q && rd_last_q;
  assign out_rsp_o      = out_q;

  // Fill count and victim pointer. Entries are filled in index order and
  // never dropped, so the count doubles as the set of valid entries.
  always_comb begin
    count_d  = count_q;
    victim_d = victim_q;
    if (cmd_i.do_write) begin
      if (!full) begin
        count_d = count_q + 1'b1;
      end else if (victim_q == IDX_W'(ENTRIES - 1)) begin
        victim_d = '0;
      end else begin
        victim_d = victim_q + 1'b1;
      end
    end
  end

  // Scan sequencing: one read issued per cycle, compared in the cycle after it is issued.
  always_comb begin
    idx_d     = idx_q;
    issue_d   = issue_q;
    rd_vld_d  = rd_vld_q;
    rd_last_d = rd_last_q;
    if (cmd_i.scan_start) begin
      idx_d    = '0;
      issue_d  = 1'b1;
      rd_vld_d = 1'b0;
    end else if (cmd_i.scan_run) begin
      rd_vld_d = issue_q;
      if (issue_q) begin
        rd_last_d = (idx_q == last_idx);
        if (idx_q == last_idx) begin
          issue_d = 1'b0;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      victim_q  <= '0;
      idx_q     <= '0;
      issue_q   <= 1'b0;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      victim_q  <= victim_d;
      idx_q     <= idx_d;
      issue_q   <= issue_d;
      rd_vld_q  <= rd_vld_d;
      rd_last_q <= rd_last_d;
    end
  end

  // Entry memory with one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_write) begin
      mem_q[wr_idx] <= '{proc_id:     req_q.proc_id,
                         page_number: req_q.page_number,
                         frame:       req_q.frame_in};
    end
    if (rd_en) begin
      rd_q <= mem_q[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_req_i;
    end
    if (cmd_i.clear_res) begin
      res_q <= '0;
    end else if (cmd_i.capture_res) begin
      res_q.hit       <= match;
      res_q.frame_out <= match ? rd_q.frame : '0;
    end
    if (cmd_i.load_out) begin
      out_q <= res_q;
    end
  end

endmodule

// ----- sv/fatlb_checker.sv -----
// Port-level checker for the translation buffer, bound to the top level.
// Depends on fatlb_pkg and on fifo_fully_associative_tlb_core's ports.
module fatlb_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input fatlb_pkg::fatlb_rsp_t out_rsp_o
);

  // A pending response stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("response withdrawn before it was taken");

  // A stalled response keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_rsp_o))
    else $error("stalled response payload changed");

  // Only one request is worked on at a time.
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request accepted while one is in progress");

  // A new response only appears at the end of a request's work.
  a_rsp_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("response produced without a request in progress");

endmodule

bind fifo_fully_associative_tlb_core fatlb_checker u_fatlb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);
